@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BCB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/bcb_pkg.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// bcb_pkg
// shared types and constants of the biome color blend pipeline
// ------------------------------------------------------------------------
package bcb_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int FIELD_W      = 13;
    localparam int ENT_W        = 63;
    localparam int MAX_BIOMES_D = 6;
    localparam int IDX_W        = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BLEND = 3'd6;
    localparam logic [IDX_W-1:0] REG_COUNT = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] height;
        logic [FIELD_W-1:0] slope;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

    // item sideband carried along the pipeline
    typedef struct packed {
        logic        blend;
        logic [23:0] fin;
        logic [23:0] lo;
        logic [23:0] up;
    } t_side;

endpackage

@@ sv/bcb_div.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// bcb_div
// pipelined restoring divider, one quotient bit per stage
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module bcb_div #(
    parameter int FRAC = bcb_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bcb_pkg::FIELD_W-1:0]   i_num,
    input  logic [bcb_pkg::FIELD_W-1:0]   i_den,
    input  bcb_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [FRAC-1:0]               o_quo,
    output bcb_pkg::t_side                o_side
);

    localparam int W = bcb_pkg::FIELD_W;

    logic                r_v   [FRAC];
    logic [W-1:0]        r_rem [FRAC];
    logic [W-1:0]        r_den [FRAC];
    logic [FRAC-1:0]     r_q   [FRAC];
    bcb_pkg::t_side      r_sd  [FRAC];

    logic [W-1:0]        p_rem [FRAC];
    logic [W-1:0]        p_den [FRAC];
    logic [FRAC-1:0]     p_q   [FRAC];
    logic [W-1:0]        n_rem [FRAC];
    logic [FRAC-1:0]     n_q   [FRAC];

    // stage inputs: the first stage takes the new item
    always_comb begin
        p_rem[0] = i_num;
        p_den[0] = i_den;
        p_q[0]   = '0;
        for (int k = 1; k < FRAC; k++) begin
            p_rem[k] = r_rem[k-1];
            p_den[k] = r_den[k-1];
            p_q[k]   = r_q[k-1];
        end
    end

    // one shift-compare-subtract per stage
    always_comb begin
        logic [W:0] sh;
        for (int k = 0; k < FRAC; k++) begin
            sh = {p_rem[k], 1'b0};
            if (sh >= {1'b0, p_den[k]}) begin
                n_rem[k] = W'(sh - {1'b0, p_den[k]});
                n_q[k]   = {p_q[k][FRAC-2:0], 1'b1};
            end else begin
                n_rem[k] = W'(sh);
                n_q[k]   = {p_q[k][FRAC-2:0], 1'b0};
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAC; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < FRAC; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 0; k < FRAC; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= p_den[k];
            end
            for (int k = 1; k < FRAC; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    assign o_valid = r_v[FRAC-1];
    assign o_quo   = r_q[FRAC-1];
    assign o_side  = r_sd[FRAC-1];

    `BCB_ASSERT(a_rem_below_den,
                r_v[FRAC-1] && r_sd[FRAC-1].blend |-> r_rem[FRAC-1] < r_den[FRAC-1],
                "divider remainder not below divisor")

endmodule

@@ sv/biome_color_blend.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// biome_color_blend
// height and slope to rgb through a biome table with smoothstep blending
// ------------------------------------------------------------------------
// registers in order: stage 1, stage 2, divider stages, p1 to p4, output register
// one item per cycle unless stalled; the divider has one stage per quotient bit
// a stall with o_valid high freezes the whole pipeline and holds the input side
// synchronous active-low reset clears all valids and all table registers
`include "assert_macros.svh"

module biome_color_blend #(
    parameter int MAX_BIOMES = bcb_pkg::MAX_BIOMES_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bcb_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [bcb_pkg::ENT_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  bcb_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output bcb_pkg::t_out                 o_data
);

    localparam int F  = bcb_pkg::FRAC_BITS;
    localparam int W  = bcb_pkg::FIELD_W;
    localparam int NB = MAX_BIOMES;

    // configuration table
    logic [bcb_pkg::ENT_W-1:0] r_biome [NB];
    logic [W-1:0]              r_range;
    logic [2:0]                r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) r_biome[i] <= '0;
            r_range <= '0;
            r_count <= '0;
        end else if (i_cfg_wr_en) begin
            for (int i = 0; i < NB; i++) begin
                if (i_cfg_idx == 3'(i)) r_biome[i] <= i_cfg_data;
            end
            if (i_cfg_idx == bcb_pkg::REG_BLEND) r_range <= i_cfg_data[W-1:0];
            if (i_cfg_idx == bcb_pkg::REG_COUNT) r_count <= i_cfg_data[2:0];
        end
    end

    logic ce;
    logic r_out_valid;
    assign ce      = !(r_out_valid && i_stall);
    assign o_stall = !ce;

    // stage 1: slope match and height compare per entry, gray level from height
    logic [2:0]    n_cnt;
    logic [NB-1:0] n_ok, n_hit;
    logic [20:0]   n_gsum;
    logic [7:0]    n_gray;

    always_comb begin
        n_cnt = (r_count > 3'(NB)) ? 3'(NB) : r_count;
        for (int i = 0; i < NB; i++) begin
            n_ok[i]  = (3'(i) < n_cnt) && (i_data.slope >= r_biome[i][49:37])
                       && (i_data.slope <= r_biome[i][36:24]);
            n_hit[i] = n_ok[i] && (i_data.height <= r_biome[i][62:50]);
        end
        n_gsum = 21'({i_data.height, 8'b0}) - 21'(i_data.height) + 21'(bcb_pkg::ONE / 2);
        n_gray = (n_gsum[20:F] > 9'd255) ? 8'd255 : n_gsum[F+7:F];
    end

    logic          r_s1_valid;
    logic [NB-1:0] r_s1_ok, r_s1_hit;
    logic [W-1:0]  r_s1_h;
    logic [7:0]    r_s1_gray;
    logic [2:0]    r_s1_cnt;
    logic [W-1:0]  r_s1_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else if (ce)  r_s1_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_ok    <= n_ok;
            r_s1_hit   <= n_hit;
            r_s1_h     <= i_data.height;
            r_s1_gray  <= n_gray;
            r_s1_cnt   <= n_cnt;
            r_s1_range <= r_range;
        end
    end

    // stage 2: pick upper and lower entries, decide the plain cases
    logic [NB-1:0]  up_oh, lo_oh, last_oh, end_oh, cand;
    logic           up_found;
    logic [23:0]    up_col, lo_col, last_col, end_col;
    logic [W-1:0]   up_ht;
    logic [15:0]    diff;
    bcb_pkg::t_side n_s2_side;
    logic [W-1:0]   n_s2_diff;

    always_comb begin
        up_oh    = '0;
        lo_oh    = '0;
        last_oh  = '0;
        end_oh   = '0;
        cand     = '0;
        up_found = 1'b0;
        for (int i = 0; i < NB; i++) begin
            if (!up_found) begin
                if (r_s1_hit[i]) begin
                    up_oh[i] = 1'b1;
                    lo_oh    = cand;
                    up_found = 1'b1;
                end else if (r_s1_ok[i]) begin
                    cand    = '0;
                    cand[i] = 1'b1;
                end
            end
            if (r_s1_ok[i]) begin
                last_oh    = '0;
                last_oh[i] = 1'b1;
            end
            end_oh[i] = (3'(i + 1) == r_s1_cnt);
        end

        up_col   = '0;
        lo_col   = '0;
        last_col = '0;
        end_col  = '0;
        up_ht    = '0;
        for (int i = 0; i < NB; i++) begin
            if (up_oh[i]) begin
                up_col = up_col | r_biome[i][23:0];
                up_ht  = up_ht | r_biome[i][62:50];
            end
            if (lo_oh[i])   lo_col   = lo_col | r_biome[i][23:0];
            if (last_oh[i]) last_col = last_col | r_biome[i][23:0];
            if (end_oh[i])  end_col  = end_col | r_biome[i][23:0];
        end

        diff = 16'(r_s1_h) + 16'(r_s1_range) - 16'(up_ht);

        n_s2_side.blend = 1'b0;
        n_s2_side.fin   = up_col;
        n_s2_side.lo    = lo_col;
        n_s2_side.up    = up_col;
        n_s2_diff       = '0;
        if (r_s1_cnt == 3'd0) begin
            n_s2_side.fin = {3{r_s1_gray}};
        end else if (!up_found) begin
            n_s2_side.fin = (|r_s1_ok) ? last_col : end_col;
        end else if (!(|lo_oh) || r_s1_range == '0) begin
            n_s2_side.fin = up_col;
        end else if (diff[15] || diff == 16'd0) begin
            n_s2_side.fin = lo_col;
        end else if (r_s1_h >= up_ht) begin
            n_s2_side.fin = up_col;
        end else begin
            n_s2_side.blend = 1'b1;
            n_s2_diff       = diff[W-1:0];
        end
    end

    logic           r_s2_valid;
    bcb_pkg::t_side r_s2_side;
    logic [W-1:0]   r_s2_diff;
    logic [W-1:0]   r_s2_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else if (ce)  r_s2_valid <= r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2_side  <= n_s2_side;
            r_s2_diff  <= n_s2_diff;
            r_s2_range <= r_s1_range;
        end
    end

    // blend weight alpha = (diff << F) / range
    logic           dv_valid;
    logic [F-1:0]   dv_alpha;
    bcb_pkg::t_side dv_side;

    bcb_div #(.FRAC(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ce),
        .i_valid (r_s2_valid),
        .i_num   (r_s2_diff),
        .i_den   (r_s2_range),
        .i_side  (r_s2_side),
        .o_valid (dv_valid),
        .o_quo   (dv_alpha),
        .o_side  (dv_side)
    );

    // smoothstep: alpha squared and 3*one - 2*alpha, their product, channel deltas
    logic           r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    bcb_pkg::t_side r_p1_side, r_p2_side, r_p3_side, r_p4_side;
    logic [2*F-1:0] r_p1_a2;
    logic [F+1:0]   r_p1_w;
    logic [3*F+1:0] r_p2_prod;
    logic [F:0]     r_p3_s;
    logic signed [F+10:0] r_p4_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (ce) begin
            r_p1_valid <= dv_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p1_side <= dv_side;
            r_p1_a2   <= dv_alpha * dv_alpha;
            r_p1_w    <= (F+2)'(3 * bcb_pkg::ONE) - {1'b0, dv_alpha, 1'b0};
            r_p2_side <= r_p1_side;
            r_p2_prod <= (3*F+2)'(r_p1_a2) * (3*F+2)'(r_p1_w);
            r_p3_side <= r_p2_side;
            r_p3_s    <= (F+1)'(r_p2_prod + ((3*F+2)'(1) << (2*F - 1)) >> (2*F));
            r_p4_side <= r_p3_side;
            for (int c = 0; c < 3; c++) begin
                r_p4_d[c] <= (F+11)'($signed({1'b0, r_p3_side.up[16-8*c +: 8]})
                             - $signed({1'b0, r_p3_side.lo[16-8*c +: 8]}))
                             * (F+11)'($signed({1'b0, r_p3_s}))
                             + (F+11)'(bcb_pkg::ONE / 2);
            end
        end
    end

    // final add with clamp when blending, else the plain color; output register
    logic [23:0] n_col;

    always_comb begin
        logic signed [11:0] v;
        n_col = r_p4_side.fin;
        for (int c = 0; c < 3; c++) begin
            v = $signed({4'b0, r_p4_side.lo[16-8*c +: 8]}) + 12'(r_p4_d[c] >>> F);
            if (r_p4_side.blend) begin
                if (v < 0)                n_col[16-8*c +: 8] = 8'd0;
                else if (v > 12'sd255)    n_col[16-8*c +: 8] = 8'd255;
                else                      n_col[16-8*c +: 8] = v[7:0];
            end
        end
    end

    bcb_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (ce)  r_out_valid <= r_p4_valid;
    end

    always_ff @(posedge i_clk) begin
        if (ce) r_out <= n_col;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BCB_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid,
                       "output valid survived reset")
    `BCB_ASSERT(a_band_diff,
                r_s2_valid && r_s2_side.blend |-> (r_s2_diff != '0) && (r_s2_diff < r_s2_range),
                "blend offset outside band")
    `BCB_ASSERT(a_stall_freezes_s2,
                r_out_valid && i_stall |=> $stable(r_s2_side) && $stable(r_s2_valid),
                "pipeline moved under stall")

endmodule
